// File: src/pmfr_pkg.sv
`timescale 1ns / 1ps
// Package for the power meter frame receiver.
// Frame layout constants, register indexes, widths and the sequencer state type.
// No dependencies.
package pmfr_pkg;

    localparam int unsigned FRAME_LEN = 24;
    localparam int unsigned POS_W     = 5;
    localparam int unsigned RAW_W     = 24;
    localparam int unsigned GAIN_W    = 32;
    localparam int unsigned MILLI_W   = 40;
    localparam int unsigned PROD_W    = RAW_W + GAIN_W;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned REG_IDX_W = 2;
    localparam int unsigned RAW_ALL_W = 3 * RAW_W;

    localparam logic [7:0]       HEADER    = 8'h55;
    localparam logic [POS_W-1:0] POS_START = 5'd0;
    localparam logic [POS_W-1:0] SUM_FIRST = 5'd2;
    localparam logic [POS_W-1:0] POS_LAST  = 5'd23;
    localparam logic [POS_W-1:0] RD_FIRST  = 5'd5;
    localparam logic [POS_W-1:0] RD_DONE   = 5'd14;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

    localparam logic [REG_IDX_W-1:0] REG_VOLTAGE_GAIN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CURRENT_GAIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_POWER_GAIN   = 2'd2;

    localparam logic [1:0] LANE_VOLTAGE = 2'd0;
    localparam logic [1:0] LANE_CURRENT = 2'd1;
    localparam logic [1:0] LANE_POWER   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCALE,
        ST_HOLD
    } t_state;

endpackage

// File: src/pmfr_rx_if.sv
`timescale 1ns / 1ps
// Byte channel into the power meter frame receiver.
// Depends on nothing.
interface pmfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/pmfr_res_if.sv
`timescale 1ns / 1ps
// Result channel of the power meter frame receiver: raw and scaled readings.
// Depends on pmfr_pkg for field widths.
interface pmfr_res_if;
    logic                           valid;
    logic                           ready;
    logic [pmfr_pkg::RAW_W-1:0]     raw_voltage;
    logic [pmfr_pkg::RAW_W-1:0]     raw_current;
    logic [pmfr_pkg::RAW_W-1:0]     raw_power;
    logic [pmfr_pkg::MILLI_W-1:0]   voltage_milli;
    logic [pmfr_pkg::MILLI_W-1:0]   current_milli;
    logic [pmfr_pkg::MILLI_W-1:0]   power_milli;

    modport source (output valid, output raw_voltage, output raw_current, output raw_power,
                    output voltage_milli, output current_milli, output power_milli,
                    input ready);
    modport sink (input valid, input raw_voltage, input raw_current, input raw_power,
                  input voltage_milli, input current_milli, input power_milli,
                  output ready);
endinterface

// File: src/pmfr_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel of the power meter frame receiver.
// Depends on pmfr_pkg for index and data widths.
interface pmfr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pmfr_pkg::REG_IDX_W-1:0]   reg_index;
    logic [pmfr_pkg::GAIN_W-1:0]      wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: src/power_meter_frame_receiver.sv
`timescale 1ns / 1ps
// Power meter frame receiver: frame assembly, checksum, readout and gain scaling.
// Depends on pmfr_pkg, pmfr_rx_if, pmfr_res_if and pmfr_cfg_if.

// The block takes one received byte per cycle on i_rx. While waiting it drops
// every byte until a 0x55 header; that byte and the next 23 form a frame, which
// is written byte by byte into a 24-entry frame memory while bytes 2 to 22 are
// summed modulo 256. When byte 23 matches the sum, a readout sequencer walks
// frame entries 5 to 13 through the memory's registered read port, then one
// shared 24x32 multiplier scales the three readings by their Q16.16 gains, one
// per cycle, and the result goes to an output register. A frame with a bad
// checksum gives no transfer. Byte intake runs at one byte per cycle; the
// readout and scaling overlaps the next frame, and only the last byte of a
// frame waits, while the previous good frame is still in the sequencer: being
// read out and scaled, or waiting for the output register, which frees once
// the result before it is taken on o_res. Gain registers are
// written on i_cfg (index 0 voltage, 1 current, 2 power; index 3 is ignored)
// and reset to 1.0.
module power_meter_frame_receiver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pmfr_rx_if.sink       i_rx,
    pmfr_cfg_if.sink      i_cfg,
    pmfr_res_if.source    o_res
);

    // frame memory, registered read: data appears in the cycle after the address is presented
    logic [7:0] r_mem [0:pmfr_pkg::FRAME_LEN-1];
    logic [7:0] r_mem_q;

    // frame assembly
    logic [pmfr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_sum, n_sum;
    logic                       w_mem_we;
    logic                       w_start;
    logic                       w_rx_fire;
    logic                       w_out_fire;

    // readout and scaling sequencer
    pmfr_pkg::t_state                 r_state, n_state;
    logic [pmfr_pkg::POS_W-1:0]       r_cnt, n_cnt;
    logic [1:0]                       r_lane, n_lane;
    logic [pmfr_pkg::RAW_ALL_W-1:0]   r_raw, n_raw;
    logic [pmfr_pkg::MILLI_W-1:0]     r_mv, n_mv;
    logic [pmfr_pkg::MILLI_W-1:0]     r_mc, n_mc;
    logic [pmfr_pkg::MILLI_W-1:0]     r_mp, n_mp;
    logic [pmfr_pkg::RAW_W-1:0]       w_mul_a;
    logic [pmfr_pkg::GAIN_W-1:0]      w_mul_b;
    logic [pmfr_pkg::PROD_W-1:0]      w_prod;
    logic                             w_load;

    // gains
    logic [pmfr_pkg::GAIN_W-1:0] r_gain_v, r_gain_c, r_gain_p;

    // output register
    logic                          r_ov, n_ov;
    logic [pmfr_pkg::RAW_W-1:0]    r_o_rv, r_o_rc, r_o_rp;
    logic [pmfr_pkg::MILLI_W-1:0]  r_o_mv, r_o_mc, r_o_mp;

    // hold the last byte while a previous good frame is still in the sequencer
    assign i_rx.ready = !((r_pos == pmfr_pkg::POS_LAST) && (r_state != pmfr_pkg::ST_IDLE));
    assign w_rx_fire  = i_rx.valid && i_rx.ready;
    assign w_out_fire = o_res.valid && o_res.ready;
    assign i_cfg.ready = 1'b1;

    // frame assembly: header hunt, store, running checksum
    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        w_mem_we = 1'b0;
        w_start  = 1'b0;
        if (w_rx_fire) begin
            if (r_pos == pmfr_pkg::POS_START) begin
                // drop anything but a header while hunting
                if (i_rx.rx_byte == pmfr_pkg::HEADER) begin
                    w_mem_we = 1'b1;
                    n_pos    = r_pos + 5'd1;
                    n_sum    = 8'd0;
                end
            end else if (r_pos == pmfr_pkg::POS_LAST) begin
                w_mem_we = 1'b1;
                n_pos    = pmfr_pkg::POS_START;
                n_sum    = 8'd0;
                w_start  = (r_sum == i_rx.rx_byte);
            end else begin
                w_mem_we = 1'b1;
                n_pos    = r_pos + 5'd1;
                if (r_pos >= pmfr_pkg::SUM_FIRST) begin
                    n_sum = r_sum + i_rx.rx_byte;
                end
            end
        end
    end

    // shared multiplier operands follow the lane
    always_comb begin
        case (r_lane)
            pmfr_pkg::LANE_VOLTAGE: begin
                w_mul_a = r_raw[3*pmfr_pkg::RAW_W-1 -: pmfr_pkg::RAW_W];
                w_mul_b = r_gain_v;
            end
            pmfr_pkg::LANE_CURRENT: begin
                w_mul_a = r_raw[2*pmfr_pkg::RAW_W-1 -: pmfr_pkg::RAW_W];
                w_mul_b = r_gain_c;
            end
            pmfr_pkg::LANE_POWER: begin
                w_mul_a = r_raw[pmfr_pkg::RAW_W-1:0];
                w_mul_b = r_gain_p;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = {{pmfr_pkg::GAIN_W{1'b0}}, w_mul_a} * {{pmfr_pkg::RAW_W{1'b0}}, w_mul_b};

    // sequencer: read entries 5..13, scale three lanes, hand off to the output register
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_lane  = r_lane;
        n_raw   = r_raw;
        n_mv    = r_mv;
        n_mc    = r_mc;
        n_mp    = r_mp;
        w_load  = 1'b0;
        case (r_state)
            pmfr_pkg::ST_IDLE: begin
                if (w_start) begin
                    n_state = pmfr_pkg::ST_READ;
                    n_cnt   = pmfr_pkg::RD_FIRST;
                end
            end
            pmfr_pkg::ST_READ: begin
                n_cnt = r_cnt + 5'd1;
                // read data arrives in the cycle after its address
                if (r_cnt != pmfr_pkg::RD_FIRST) begin
                    n_raw = {r_raw[pmfr_pkg::RAW_ALL_W-9:0], r_mem_q};
                end
                if (r_cnt == pmfr_pkg::RD_DONE) begin
                    n_state = pmfr_pkg::ST_SCALE;
                    n_lane  = pmfr_pkg::LANE_VOLTAGE;
                end
            end
            pmfr_pkg::ST_SCALE: begin
                n_lane = r_lane + 2'd1;
                case (r_lane)
                    pmfr_pkg::LANE_VOLTAGE: n_mv = w_prod[pmfr_pkg::PROD_W-1:pmfr_pkg::FRAC_W];
                    pmfr_pkg::LANE_CURRENT: n_mc = w_prod[pmfr_pkg::PROD_W-1:pmfr_pkg::FRAC_W];
                    pmfr_pkg::LANE_POWER:   n_mp = w_prod[pmfr_pkg::PROD_W-1:pmfr_pkg::FRAC_W];
                    default:                n_mv = r_mv;
                endcase
                if (r_lane == pmfr_pkg::LANE_POWER) begin
                    n_state = pmfr_pkg::ST_HOLD;
                end
            end
            pmfr_pkg::ST_HOLD: begin
                // wait until the output register is free or being drained
                if (!r_ov || w_out_fire) begin
                    w_load  = 1'b1;
                    n_state = pmfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pmfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov && !w_out_fire;
        if (w_load) begin
            n_ov = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= pmfr_pkg::POS_START;
            r_sum    <= 8'd0;
            r_state  <= pmfr_pkg::ST_IDLE;
            r_cnt    <= pmfr_pkg::RD_FIRST;
            r_lane   <= pmfr_pkg::LANE_VOLTAGE;
            r_ov     <= 1'b0;
            r_gain_v <= pmfr_pkg::GAIN_RESET;
            r_gain_c <= pmfr_pkg::GAIN_RESET;
            r_gain_p <= pmfr_pkg::GAIN_RESET;
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lane  <= n_lane;
            r_ov    <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    pmfr_pkg::REG_VOLTAGE_GAIN: r_gain_v <= i_cfg.wr_data;
                    pmfr_pkg::REG_CURRENT_GAIN: r_gain_c <= i_cfg.wr_data;
                    pmfr_pkg::REG_POWER_GAIN:   r_gain_p <= i_cfg.wr_data;
                    default:                    r_gain_v <= r_gain_v;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_raw <= n_raw;
        r_mv  <= n_mv;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
        if (w_load) begin
            r_o_rv <= r_raw[3*pmfr_pkg::RAW_W-1 -: pmfr_pkg::RAW_W];
            r_o_rc <= r_raw[2*pmfr_pkg::RAW_W-1 -: pmfr_pkg::RAW_W];
            r_o_rp <= r_raw[pmfr_pkg::RAW_W-1:0];
            r_o_mv <= r_mv;
            r_o_mc <= r_mc;
            r_o_mp <= r_mp;
        end
    end

    // frame memory: one write port from assembly, one read port for the readout.
    // The next frame cannot write an entry before the readout has read it, so the
    // readout always sees the previous frame's bytes.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_pos] <= i_rx.rx_byte;
        end
        r_mem_q <= r_mem[r_cnt];
    end

    assign o_res.valid         = r_ov;
    assign o_res.raw_voltage   = r_o_rv;
    assign o_res.raw_current   = r_o_rc;
    assign o_res.raw_power     = r_o_rp;
    assign o_res.voltage_milli = r_o_mv;
    assign o_res.current_milli = r_o_mc;
    assign o_res.power_milli   = r_o_mp;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for power_meter_frame_receiver: directed and random byte streams under
// several gain settings and flow-control patterns, checked by a frame scoreboard.
// Depends on pmfr_pkg, the rx/cfg/res channel interfaces and the receiver RTL.
module tb_top;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int HOLD_CYCLES      = 400;
    localparam int PHASES           = 8;
    localparam int FRAMES_PER_PHASE = 6;

    // Index past the three gain registers; the block must ignore writes to it.
    localparam logic [pmfr_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } t_idle;

    typedef struct packed {
        logic [pmfr_pkg::RAW_W-1:0]   raw_voltage;
        logic [pmfr_pkg::RAW_W-1:0]   raw_current;
        logic [pmfr_pkg::RAW_W-1:0]   raw_power;
        logic [pmfr_pkg::MILLI_W-1:0] voltage_milli;
        logic [pmfr_pkg::MILLI_W-1:0] current_milli;
        logic [pmfr_pkg::MILLI_W-1:0] power_milli;
    } t_reading;

    // Tracks frame assembly byte by byte and queues the reading that each good
    // frame must produce.
    class frame_scoreboard;
        logic [pmfr_pkg::GAIN_W-1:0] voltage_gain;
        logic [pmfr_pkg::GAIN_W-1:0] current_gain;
        logic [pmfr_pkg::GAIN_W-1:0] power_gain;
        logic [pmfr_pkg::POS_W-1:0]  position;
        logic [7:0]                  checksum;
        logic [7:0]                  frame [pmfr_pkg::FRAME_LEN];
        t_reading                    readings_q [$];
        int                          errors;

        function new();
            voltage_gain = pmfr_pkg::GAIN_RESET;
            current_gain = pmfr_pkg::GAIN_RESET;
            power_gain   = pmfr_pkg::GAIN_RESET;
            position     = pmfr_pkg::POS_START;
            checksum     = 8'd0;
            errors       = 0;
        endfunction

        function void set_gain(logic [pmfr_pkg::REG_IDX_W-1:0] index,
                               logic [pmfr_pkg::GAIN_W-1:0] value);
            case (index)
                pmfr_pkg::REG_VOLTAGE_GAIN: voltage_gain = value;
                pmfr_pkg::REG_CURRENT_GAIN: current_gain = value;
                pmfr_pkg::REG_POWER_GAIN:   power_gain   = value;
                default: ;
            endcase
        endfunction

        function logic [pmfr_pkg::MILLI_W-1:0] scale(logic [pmfr_pkg::RAW_W-1:0] raw,
                                                     logic [pmfr_pkg::GAIN_W-1:0] gain);
            logic [pmfr_pkg::PROD_W-1:0] prod;
            prod = pmfr_pkg::PROD_W'(raw) * pmfr_pkg::PROD_W'(gain);
            return prod[pmfr_pkg::PROD_W-1:pmfr_pkg::FRAC_W];
        endfunction

        function logic [pmfr_pkg::RAW_W-1:0] take_reading(int at);
            return {frame[at], frame[at+1], frame[at+2]};
        endfunction

        function void note_byte(logic [7:0] b);
            t_reading r;
            // drop anything but a header while waiting for a frame
            if (position == pmfr_pkg::POS_START && b != pmfr_pkg::HEADER)
                return;
            if (position == pmfr_pkg::POS_START)
                checksum = 8'd0;
            frame[position] = b;
            if (position != pmfr_pkg::POS_LAST) begin
                if (position >= pmfr_pkg::SUM_FIRST)
                    checksum = checksum + b;
                position = position + 1'b1;
                return;
            end
            position = pmfr_pkg::POS_START;
            if (checksum != b)
                return;
            r.raw_voltage   = take_reading(int'(pmfr_pkg::RD_FIRST));
            r.raw_current   = take_reading(int'(pmfr_pkg::RD_FIRST) + 3);
            r.raw_power     = take_reading(int'(pmfr_pkg::RD_FIRST) + 6);
            r.voltage_milli = scale(r.raw_voltage, voltage_gain);
            r.current_milli = scale(r.raw_current, current_gain);
            r.power_milli   = scale(r.raw_power, power_gain);
            readings_q.push_back(r);
        endfunction

        function void compare(string name, logic [pmfr_pkg::MILLI_W-1:0] want,
                              logic [pmfr_pkg::MILLI_W-1:0] got);
            if (want !== got) begin
                $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (readings_q.size() == 0) begin
                $display("%0t ns: reading with no good frame pending, got %h", $time, got);
                errors++;
                return;
            end
            want = readings_q.pop_front();
            compare("raw_voltage", want.raw_voltage, got.raw_voltage);
            compare("raw_current", want.raw_current, got.raw_current);
            compare("raw_power", want.raw_power, got.raw_power);
            compare("voltage_milli", want.voltage_milli, got.voltage_milli);
            compare("current_milli", want.current_milli, got.current_milli);
            compare("power_milli", want.power_milli, got.power_milli);
        endfunction

        function int pending();
            return readings_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pmfr_rx_if  rx_ch ();
    pmfr_cfg_if cfg_ch ();
    pmfr_res_if res_ch ();

    power_meter_frame_receiver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    frame_scoreboard board = new();

    // Per-cycle idle chance of each side, in percent; set per phase.
    int src_pct       = 0;
    int snk_pct       = 0;
    // Bump to ask the result side for one long hold-off.
    int hold_requests = 0;
    int cycle_count   = 0;

    logic [7:0] frame_buf [pmfr_pkg::FRAME_LEN];

    always #2 i_clk = ~i_clk;

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: drive ready at the falling edge, either random stalls or a
    // long hold-off when one is requested, so the block backs up into its input.
    initial begin
        int hold_left;
        int served;
        hold_left    = 0;
        served       = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= snk_pct);
            end
        end
    end

    // Sample every result transfer at the rising edge and hand it to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_reading('{res_ch.raw_voltage, res_ch.raw_current, res_ch.raw_power,
                                  res_ch.voltage_milli, res_ch.current_milli,
                                  res_ch.power_milli});
    end

    // Bias toward the byte values that matter: zero, all ones and the header.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return pmfr_pkg::HEADER;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one byte; keep valid high across back-to-back transfers, drop it only
    // for idle cycles, and note the byte once the transfer happens.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        board.note_byte(b);
    endtask

    // Fill in the checksum byte of frame_buf (spoiled on request) and send the frame.
    task automatic send_frame(input bit corrupt);
        logic [7:0] sum;
        sum = 8'd0;
        for (int i = int'(pmfr_pkg::SUM_FIRST); i < int'(pmfr_pkg::POS_LAST); i++)
            sum = sum + frame_buf[i];
        frame_buf[pmfr_pkg::POS_LAST] = corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (int i = 0; i < pmfr_pkg::FRAME_LEN; i++)
            send_byte(frame_buf[i]);
    endtask

    task automatic write_reg(input logic [pmfr_pkg::REG_IDX_W-1:0] index,
                             input logic [pmfr_pkg::GAIN_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= index;
        cfg_ch.wr_data   <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_gain(index, value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_gains(input logic [pmfr_pkg::GAIN_W-1:0] v,
                                 input logic [pmfr_pkg::GAIN_W-1:0] c,
                                 input logic [pmfr_pkg::GAIN_W-1:0] p);
        write_reg(pmfr_pkg::REG_VOLTAGE_GAIN, v);
        write_reg(pmfr_pkg::REG_CURRENT_GAIN, c);
        write_reg(pmfr_pkg::REG_POWER_GAIN, p);
    endtask

    // Stop offering, wait for every pending reading, then let the block settle
    // before anything else changes.
    task automatic drain();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_idle      mode;
        logic [7:0] noise;
        int         at;

        rx_ch.valid      = 1'b0;
        rx_ch.rx_byte    = 8'h00;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = pmfr_pkg::REG_VOLTAGE_GAIN;
        cfg_ch.wr_data   = '0;
        i_rst_n          = 1'b0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: non-header bytes while waiting are dropped, then one frame with
        // all-ones voltage, zero current, and header bytes used as ordinary data.
        send_byte(8'h00);
        send_byte(8'hFF);
        frame_buf[0] = pmfr_pkg::HEADER;
        frame_buf[1] = 8'hFF;
        frame_buf[2] = 8'h00;
        frame_buf[3] = 8'hFF;
        frame_buf[4] = pmfr_pkg::HEADER;
        for (int i = 0; i < 3; i++) begin
            frame_buf[int'(pmfr_pkg::RD_FIRST) + i]     = 8'hFF;
            frame_buf[int'(pmfr_pkg::RD_FIRST) + 3 + i] = 8'h00;
            frame_buf[int'(pmfr_pkg::RD_FIRST) + 6 + i] = pmfr_pkg::HEADER;
        end
        for (int i = int'(pmfr_pkg::RD_DONE); i < int'(pmfr_pkg::POS_LAST); i++)
            frame_buf[i] = 8'hFF;
        send_frame(1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            // Gains change only with the block idle; the reset values serve phase 0.
            if (phase > 0) begin
                drain();
                case (phase)
                    1: program_gains('1, '1, '1);
                    2: program_gains('0, '0, '0);
                    4: program_gains(pmfr_pkg::GAIN_RESET, $urandom, '1);
                    6: program_gains($urandom_range(32'h0002_0000), $urandom_range(32'h0002_0000),
                                     $urandom_range(32'h0002_0000));
                    7: program_gains('1, '0, pmfr_pkg::GAIN_RESET);
                    default: program_gains($urandom, $urandom, $urandom);
                endcase
                if (phase == 3)
                    write_reg(REG_UNUSED, $urandom);
            end

            mode = t_idle'(phase % 4);
            case (mode)
                IDLE_SRC:  begin src_pct = 80; snk_pct = 0;  end
                IDLE_SNK:  begin src_pct = 0;  snk_pct = 80; end
                IDLE_BOTH: begin src_pct = 37; snk_pct = 37; end
                default:   begin src_pct = 0;  snk_pct = 0;  end
            endcase
            // Hold off results for a long stretch while bytes keep coming.
            if (phase == 4)
                hold_requests++;

            repeat (FRAMES_PER_PHASE) begin
                // Line noise between frames; a stray header now and then breaks
                // the alignment of the frame that follows.
                repeat ($urandom_range(3)) begin
                    noise = rand_byte();
                    if (noise == pmfr_pkg::HEADER && $urandom_range(7) != 0)
                        noise = ~pmfr_pkg::HEADER;
                    send_byte(noise);
                end
                frame_buf[0] = pmfr_pkg::HEADER;
                for (int i = 1; i < int'(pmfr_pkg::POS_LAST); i++)
                    frame_buf[i] = rand_byte();
                // Force a reading to its extremes now and then.
                for (int k = 0; k < 3; k++) begin
                    at = int'(pmfr_pkg::RD_FIRST) + 3 * k;
                    case ($urandom_range(7))
                        0: begin
                            frame_buf[at]     = 8'hFF;
                            frame_buf[at + 1] = 8'hFF;
                            frame_buf[at + 2] = 8'hFF;
                        end
                        1: begin
                            frame_buf[at]     = 8'h00;
                            frame_buf[at + 1] = 8'h00;
                            frame_buf[at + 2] = 8'h00;
                        end
                        default: ;
                    endcase
                end
                send_frame($urandom_range(9) == 0);
            end
        end

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
